[hw/rtl/gwhm_pkg.sv]
package gwhm_pkg;

    localparam int WINDOW_DEFAULT = 10;

    localparam int RATE_W    = 30;
    localparam int SQR_W     = 59;
    localparam int REG_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int STATUS_W  = 2;

    localparam int IN_TDATA_W    = 64;
    localparam int OUT_PAYLOAD_W = STATUS_W + 2 * RATE_W + 1;
    localparam int OUT_TDATA_W   = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_OPTICAL_ENABLED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCREPANCY_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMS_STUCK_FLOOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTICAL_STUCK_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_GUARD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_LIMIT      = 3'd5;

    localparam logic [REG_W-1:0] RST_DISCREPANCY_LIMIT   = 31'd262144;
    localparam logic [REG_W-1:0] RST_MEMS_STUCK_FLOOR    = 31'd4719;
    localparam logic [REG_W-1:0] RST_OPTICAL_STUCK_FLOOR = 31'd776;
    localparam logic [REG_W-1:0] RST_SATURATION_GUARD    = 31'd188743680;
    localparam logic [REG_W-1:0] RST_ROTATION_LIMIT      = 31'd5242880;

    localparam logic [STATUS_W-1:0] STATUS_UNAVAILABLE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_GOOD        = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD         = 2'd2;

    typedef struct packed {
        logic filled;
        logic stuck;
    } t_lane_flags;

endpackage

[hw/rtl/gwhm_lane.sv]
module gwhm_lane #(
    parameter int WINDOW = gwhm_pkg::WINDOW_DEFAULT
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_adv,
    input  logic                                                  i_push,
    input  logic signed [gwhm_pkg::RATE_W-1:0]                    i_sample,
    input  logic        [gwhm_pkg::REG_W-1:0]                     i_stuck_floor,
    output logic signed [gwhm_pkg::RATE_W+$clog2(WINDOW)-1:0]     o_sum,
    output logic signed [gwhm_pkg::RATE_W-1:0]                    o_mean,
    output gwhm_pkg::t_lane_flags                                 o_flags
);

    localparam int RATE_W = gwhm_pkg::RATE_W;
    localparam int SQR_W  = gwhm_pkg::SQR_W;
    localparam int REG_W  = gwhm_pkg::REG_W;
    localparam int CW     = $clog2(WINDOW);
    localparam int SUM_W  = RATE_W + CW;
    localparam int SQS_W  = SQR_W + CW;
    localparam int CMP_W  = 2 * SUM_W + 3;
    localparam int RCP_W  = REG_W;
    localparam int PRD_W  = SUM_W + RCP_W;

    // Reciprocal of the window size scaled by 2^SUM_W; the estimate it gives
    // is at most one below the true quotient.
    localparam longint unsigned RECIP_L = (longint'(1) << SUM_W) / WINDOW;
    localparam logic [RCP_W-1:0] RECIP  = RCP_W'(RECIP_L);

    localparam logic [CW-1:0]    LAST_POS  = CW'(WINDOW - 1);
    localparam logic [SUM_W-1:0] WIN_S     = SUM_W'(WINDOW);
    localparam logic [CMP_W-1:0] WIN_C     = CMP_W'(WINDOW);
    localparam logic [CMP_W-1:0] WIN_SQ_C  = CMP_W'(WINDOW * WINDOW);

    // Window state.
    logic signed [RATE_W-1:0] r_win [WINDOW];
    logic        [SQR_W-1:0]  r_wsq [WINDOW];
    logic signed [SUM_W-1:0]  r_sum;
    logic        [SQS_W-1:0]  r_sqsum;
    logic        [CW-1:0]     r_pos;
    logic                     r_filled;

    logic signed [2*RATE_W-1:0] x_prod;
    logic        [SQR_W-1:0]    x_sq;
    logic signed [RATE_W-1:0]   old_x;
    logic        [SQR_W-1:0]    old_sq;
    logic signed [SUM_W-1:0]    n_sum;
    logic        [SQS_W-1:0]    n_sqsum;

    assign x_prod  = i_sample * i_sample;
    assign x_sq    = x_prod[SQR_W-1:0];
    assign old_x   = r_win[r_pos];
    assign old_sq  = r_wsq[r_pos];
    assign n_sum   = r_sum + SUM_W'(i_sample) - SUM_W'(old_x);
    assign n_sqsum = r_sqsum + SQS_W'(x_sq) - SQS_W'(old_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_win[k] <= '0;
                r_wsq[k] <= '0;
            end
            r_sum    <= '0;
            r_sqsum  <= '0;
            r_pos    <= '0;
            r_filled <= 1'b0;
        end else if (i_push) begin
            r_win[r_pos] <= i_sample;
            r_wsq[r_pos] <= x_sq;
            r_sum        <= n_sum;
            r_sqsum      <= n_sqsum;
            if (r_pos == LAST_POS) begin
                r_pos    <= '0;
                r_filled <= 1'b1;
            end else begin
                r_pos <= r_pos + CW'(1);
            end
        end
    end

    // Floor term W^2 * floor^2, recomputed every cycle from the register.
    logic [2*REG_W-1:0] r_fsq;
    logic [CMP_W-1:0]   r_fterm;

    always_ff @(posedge i_clk) begin
        r_fsq   <= i_stuck_floor * i_stuck_floor;
        r_fterm <= CMP_W'(r_fsq) * WIN_SQ_C;
    end

    // Snapshot of the state after this item's update.
    logic signed [SUM_W-1:0] r_b_sum;
    logic        [SUM_W-1:0] r_b_mag;
    logic        [SQS_W-1:0] r_b_sq;
    logic                    r_b_filled;
    logic        [SUM_W-1:0] sum_mag;

    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    // Products.
    logic signed [SUM_W-1:0]   r_c_sum;
    logic        [SUM_W-1:0]   r_c_mag;
    logic                      r_c_filled;
    logic        [2*SUM_W-1:0] r_c_ss;
    logic        [CMP_W-1:0]   r_c_wq;
    logic        [PRD_W-1:0]   r_c_prod;
    logic        [2*SUM_W-1:0] ss_prod;
    logic        [PRD_W-1:0]   rcp_prod;

    assign ss_prod  = r_b_mag * r_b_mag;
    assign rcp_prod = PRD_W'(r_b_mag) * PRD_W'(RECIP);

    // Stuck compare and quotient estimate.
    logic signed [SUM_W-1:0]  r_d_sum;
    logic        [SUM_W-1:0]  r_d_mag;
    logic                     r_d_filled;
    logic                     r_d_stuck;
    logic        [RATE_W-1:0] r_d_qest;
    logic        [SUM_W-1:0]  r_d_qw;
    logic        [RATE_W-1:0] qest;
    logic        [SUM_W-1:0]  qw;

    assign qest = r_c_prod[SUM_W +: RATE_W];
    assign qw   = SUM_W'(qest) * WIN_S;

    // Quotient correction and sign.
    logic        [SUM_W-1:0]  rem;
    logic        [RATE_W-1:0] quo;
    logic signed [RATE_W-1:0] mean;

    assign rem  = r_d_mag - r_d_qw;
    assign quo  = r_d_qest + RATE_W'(rem >= WIN_S);
    assign mean = !r_d_filled ? '0 : (r_d_sum[SUM_W-1] ? RATE_W'(-quo) : RATE_W'(quo));

    logic signed [SUM_W-1:0]  r_e_sum;
    logic signed [RATE_W-1:0] r_e_mean;
    gwhm_pkg::t_lane_flags    r_e_flags;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_sum    <= r_sum;
            r_b_mag    <= sum_mag;
            r_b_sq     <= r_sqsum;
            r_b_filled <= r_filled;

            r_c_sum    <= r_b_sum;
            r_c_mag    <= r_b_mag;
            r_c_filled <= r_b_filled;
            r_c_ss     <= ss_prod;
            r_c_wq     <= CMP_W'(r_b_sq) * WIN_C;
            r_c_prod   <= rcp_prod;

            r_d_sum    <= r_c_sum;
            r_d_mag    <= r_c_mag;
            r_d_filled <= r_c_filled;
            r_d_stuck  <= r_c_wq < (CMP_W'(r_c_ss) + r_fterm);
            r_d_qest   <= qest;
            r_d_qw     <= qw;

            r_e_sum          <= r_d_sum;
            r_e_mean         <= mean;
            r_e_flags.filled <= r_d_filled;
            r_e_flags.stuck  <= r_d_stuck;
        end
    end

    assign o_sum   = r_e_sum;
    assign o_mean  = r_e_mean;
    assign o_flags = r_e_flags;

endmodule

[hw/rtl/gwhm_merge.sv]
module gwhm_merge #(
    parameter int WINDOW = gwhm_pkg::WINDOW_DEFAULT
) (
    input  logic                                              i_clk,
    input  logic                                              i_adv,
    input  logic                                              i_optical_enabled,
    input  logic        [gwhm_pkg::REG_W-1:0]                 i_discrepancy_limit,
    input  logic        [gwhm_pkg::REG_W-1:0]                 i_saturation_guard,
    input  logic        [gwhm_pkg::REG_W-1:0]                 i_rotation_limit,
    input  logic signed [gwhm_pkg::RATE_W+$clog2(WINDOW)-1:0] i_mems_sum,
    input  logic signed [gwhm_pkg::RATE_W+$clog2(WINDOW)-1:0] i_optical_sum,
    input  logic signed [gwhm_pkg::RATE_W-1:0]                i_mems_mean,
    input  logic signed [gwhm_pkg::RATE_W-1:0]                i_optical_mean,
    input  gwhm_pkg::t_lane_flags                             i_mems_flags,
    input  gwhm_pkg::t_lane_flags                             i_optical_flags,
    output logic        [gwhm_pkg::STATUS_W-1:0]              o_status,
    output logic signed [gwhm_pkg::RATE_W-1:0]                o_mems_mean,
    output logic signed [gwhm_pkg::RATE_W-1:0]                o_optical_mean,
    output logic                                              o_not_rotating
);

    localparam int RATE_W = gwhm_pkg::RATE_W;
    localparam int CW     = $clog2(WINDOW);
    localparam int SUM_W  = RATE_W + CW;
    localparam int GW     = gwhm_pkg::REG_W + CW;

    localparam logic [GW-1:0] WIN_G = GW'(WINDOW);

    // Thresholds scaled by the window size so they compare against sums.
    logic [GW-1:0] r_wlimit;
    logic [GW-1:0] r_wguard;
    logic [GW-1:0] r_wrot;

    always_ff @(posedge i_clk) begin
        r_wlimit <= GW'(i_discrepancy_limit) * WIN_G;
        r_wguard <= GW'(i_saturation_guard) * WIN_G;
        r_wrot   <= GW'(i_rotation_limit) * WIN_G;
    end

    logic signed [GW-1:0]    diff;
    logic        [GW-1:0]    gap;
    logic        [SUM_W-1:0] mems_mag;
    logic signed [SUM_W-1:0] sel;
    logic        [SUM_W-1:0] sel_mag;

    assign diff     = GW'(i_mems_sum) - GW'(i_optical_sum);
    assign gap      = diff[GW-1] ? GW'(-diff) : GW'(diff);
    assign mems_mag = i_mems_sum[SUM_W-1] ? SUM_W'(-i_mems_sum) : SUM_W'(i_mems_sum);
    assign sel      = (i_optical_enabled && i_optical_flags.filled) ? i_optical_sum :
                      (i_mems_flags.filled ? i_mems_sum : '0);
    assign sel_mag  = sel[SUM_W-1] ? SUM_W'(-sel) : SUM_W'(sel);

    logic        [GW-1:0]     r_gap;
    logic        [SUM_W-1:0]  r_mems_mag;
    logic        [SUM_W-1:0]  r_sel_mag;
    gwhm_pkg::t_lane_flags    r_mems_flags;
    gwhm_pkg::t_lane_flags    r_optical_flags;
    logic signed [RATE_W-1:0] r_mems_mean;
    logic signed [RATE_W-1:0] r_optical_mean;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_gap           <= gap;
            r_mems_mag      <= mems_mag;
            r_sel_mag       <= sel_mag;
            r_mems_flags    <= i_mems_flags;
            r_optical_flags <= i_optical_flags;
            r_mems_mean     <= i_mems_mean;
            r_optical_mean  <= i_optical_mean;
        end
    end

    always_comb begin
        if (!r_mems_flags.filled || (i_optical_enabled && !r_optical_flags.filled)) begin
            o_status = gwhm_pkg::STATUS_UNAVAILABLE;
        end else if (!i_optical_enabled) begin
            o_status = r_mems_flags.stuck ? gwhm_pkg::STATUS_BAD : gwhm_pkg::STATUS_GOOD;
        end else if (GW'(r_mems_mag) > r_wguard) begin
            // A saturated MEMS channel cannot be compared against the optical one.
            o_status = gwhm_pkg::STATUS_GOOD;
        end else if (r_gap > r_wlimit || r_mems_flags.stuck || r_optical_flags.stuck) begin
            o_status = gwhm_pkg::STATUS_BAD;
        end else begin
            o_status = gwhm_pkg::STATUS_GOOD;
        end
    end

    assign o_mems_mean    = r_mems_mean;
    assign o_optical_mean = r_optical_mean;
    assign o_not_rotating = GW'(r_sel_mag) < r_wrot;

endmodule

[hw/rtl/gyro_window_health_monitor.sv]
// Gyro health monitor over a rolling window of WINDOW yaw-rate samples per
// channel. Each transfer on the slave side carries one MEMS and one optical
// sample and produces exactly one result on the master side, after passing
// the window state, the lane stages, the merge stage and the output register.
// A new sample can be taken every cycle while the skid register is empty:
// the running sum and sum of squares of each channel are updated once per
// sample, and that update sets the rate. The MEMS and optical channels run in
// two identical lanes that compute the window means and the stuck-channel
// test; a merge stage compares the lanes and forms the status. The optical
// window only advances while optical_enabled is set. Status reads unavailable
// until the windows in use have filled. Configuration writes should be made
// while no sample is in flight.
module gyro_window_health_monitor #(
    parameter int WINDOW = gwhm_pkg::WINDOW_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [29:0] mems_rate, [59:30] optical_rate, [63:60] zero
    input  logic [gwhm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] status_code, [31:2] mems_mean, [61:32] optical_mean,
    // [62] not_rotating, [63] zero
    output logic [gwhm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,

    input  logic                                i_cfg_wr_en,
    input  logic [gwhm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gwhm_pkg::REG_W-1:0]          i_cfg_data
);

    localparam int RATE_W     = gwhm_pkg::RATE_W;
    localparam int REG_W      = gwhm_pkg::REG_W;
    localparam int SUM_W      = RATE_W + $clog2(WINDOW);
    localparam int PAYLOAD_W  = gwhm_pkg::OUT_PAYLOAD_W;
    // State stage, four lane stages and one merge stage.
    localparam int PIPE_STAGES = 6;

    // Configuration registers.
    logic             r_optical_enabled;
    logic [REG_W-1:0] r_discrepancy_limit;
    logic [REG_W-1:0] r_mems_stuck_floor;
    logic [REG_W-1:0] r_optical_stuck_floor;
    logic [REG_W-1:0] r_saturation_guard;
    logic [REG_W-1:0] r_rotation_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_optical_enabled     <= 1'b1;
            r_discrepancy_limit   <= gwhm_pkg::RST_DISCREPANCY_LIMIT;
            r_mems_stuck_floor    <= gwhm_pkg::RST_MEMS_STUCK_FLOOR;
            r_optical_stuck_floor <= gwhm_pkg::RST_OPTICAL_STUCK_FLOOR;
            r_saturation_guard    <= gwhm_pkg::RST_SATURATION_GUARD;
            r_rotation_limit      <= gwhm_pkg::RST_ROTATION_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                gwhm_pkg::CFG_OPTICAL_ENABLED:     r_optical_enabled     <= i_cfg_data[0];
                gwhm_pkg::CFG_DISCREPANCY_LIMIT:   r_discrepancy_limit   <= i_cfg_data;
                gwhm_pkg::CFG_MEMS_STUCK_FLOOR:    r_mems_stuck_floor    <= i_cfg_data;
                gwhm_pkg::CFG_OPTICAL_STUCK_FLOOR: r_optical_stuck_floor <= i_cfg_data;
                gwhm_pkg::CFG_SATURATION_GUARD:    r_saturation_guard    <= i_cfg_data;
                gwhm_pkg::CFG_ROTATION_LIMIT:      r_rotation_limit      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves as a whole while the skid register is empty.
    logic r_skid_vld;
    logic r_out_vld;
    logic adv;
    logic accept;

    assign adv           = !r_skid_vld;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    logic [PIPE_STAGES-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], accept};
        end
    end

    logic signed [RATE_W-1:0] mems_rate;
    logic signed [RATE_W-1:0] optical_rate;

    assign mems_rate    = s_axis_tdata[RATE_W-1:0];
    assign optical_rate = s_axis_tdata[2*RATE_W-1:RATE_W];

    logic signed [SUM_W-1:0]  mems_sum;
    logic signed [SUM_W-1:0]  optical_sum;
    logic signed [RATE_W-1:0] mems_mean;
    logic signed [RATE_W-1:0] optical_mean;
    gwhm_pkg::t_lane_flags    mems_flags;
    gwhm_pkg::t_lane_flags    optical_flags;

    gwhm_lane #(.WINDOW(WINDOW)) u_mems_lane (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_push        (accept),
        .i_sample      (mems_rate),
        .i_stuck_floor (r_mems_stuck_floor),
        .o_sum         (mems_sum),
        .o_mean        (mems_mean),
        .o_flags       (mems_flags)
    );

    gwhm_lane #(.WINDOW(WINDOW)) u_optical_lane (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_push        (accept && r_optical_enabled),
        .i_sample      (optical_rate),
        .i_stuck_floor (r_optical_stuck_floor),
        .o_sum         (optical_sum),
        .o_mean        (optical_mean),
        .o_flags       (optical_flags)
    );

    logic [gwhm_pkg::STATUS_W-1:0] status;
    logic signed [RATE_W-1:0]      out_mems_mean;
    logic signed [RATE_W-1:0]      out_optical_mean;
    logic                          not_rotating;

    gwhm_merge #(.WINDOW(WINDOW)) u_merge (
        .i_clk               (i_clk),
        .i_adv               (adv),
        .i_optical_enabled   (r_optical_enabled),
        .i_discrepancy_limit (r_discrepancy_limit),
        .i_saturation_guard  (r_saturation_guard),
        .i_rotation_limit    (r_rotation_limit),
        .i_mems_sum          (mems_sum),
        .i_optical_sum       (optical_sum),
        .i_mems_mean         (mems_mean),
        .i_optical_mean      (optical_mean),
        .i_mems_flags        (mems_flags),
        .i_optical_flags     (optical_flags),
        .o_status            (status),
        .o_mems_mean         (out_mems_mean),
        .o_optical_mean      (out_optical_mean),
        .o_not_rotating      (not_rotating)
    );

    logic [PAYLOAD_W-1:0] result;
    logic [PAYLOAD_W-1:0] r_out_data;
    logic [PAYLOAD_W-1:0] r_skid_data;
    logic                 result_vld;
    logic                 take;

    assign result     = {not_rotating, out_optical_mean, out_mems_mean, status};
    assign result_vld = r_vld[PIPE_STAGES-1] && adv;
    assign take       = r_out_vld && m_axis_tready;

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (result_vld) begin
            if (r_out_vld && !take) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out_data <= r_skid_data;
            end
        end else if (result_vld) begin
            if (r_out_vld && !take) begin
                r_skid_data <= result;
            end else begin
                r_out_data <= result;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(gwhm_pkg::OUT_TDATA_W - PAYLOAD_W){1'b0}}, r_out_data};

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry holds a result while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !m_axis_tready))
        else $error("skid entry filled without a stalled output");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("status code out of range");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int     WIN         = gwhm_pkg::WINDOW_DEFAULT;
    localparam int     RATE_W      = gwhm_pkg::RATE_W;
    localparam int     REG_W       = gwhm_pkg::REG_W;
    localparam int     STATUS_W    = gwhm_pkg::STATUS_W;
    localparam int     CFG_IDX_W   = gwhm_pkg::CFG_IDX_W;
    localparam int     IN_TDATA_W  = gwhm_pkg::IN_TDATA_W;
    localparam int     OUT_TDATA_W = gwhm_pkg::OUT_TDATA_W;
    localparam longint RATE_MAX    = 64'sd536870911;
    localparam longint RATE_MIN    = -64'sd536870912;
    localparam int     LANE_MEMS   = 0;
    localparam int     LANE_OPT    = 1;
    localparam int     SETTLE      = 12;
    localparam int     PHASE_ITEMS = 180;
    localparam int     CYCLE_LIMIT = 300000;

    // Indexes past the last register; writes to them must leave the block unchanged.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic [STATUS_W-1:0] status_code;
        logic [RATE_W-1:0]   mems_mean;
        logic [RATE_W-1:0]   optical_mean;
        logic                not_rotating;
    } t_health;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [REG_W-1:0]       i_cfg_data = '0;

    gyro_window_health_monitor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [29:0] mems_rate, [59:30] optical_rate, [63:60] zero
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [1:0] status_code, [31:2] mems_mean, [61:32] optical_mean,
        // [62] not_rotating, [63] zero
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copies as the block should hold them.
    bit               cfg_optical_en = 1'b1;
    logic [REG_W-1:0] cfg_gap_limit  = gwhm_pkg::RST_DISCREPANCY_LIMIT;
    logic [REG_W-1:0] cfg_mems_floor = gwhm_pkg::RST_MEMS_STUCK_FLOOR;
    logic [REG_W-1:0] cfg_opt_floor  = gwhm_pkg::RST_OPTICAL_STUCK_FLOOR;
    logic [REG_W-1:0] cfg_sat_guard  = gwhm_pkg::RST_SATURATION_GUARD;
    logic [REG_W-1:0] cfg_rot_limit  = gwhm_pkg::RST_ROTATION_LIMIT;

    // Window state per lane.
    longint lane_hist [2][WIN];
    longint lane_sum  [2];
    longint lane_sq   [2];
    int     lane_pos  [2];
    bit     lane_full [2];

    logic [IN_TDATA_W-1:0] rate_samples [$];
    t_health               health_reports [$];

    bit calm = 1'b0;
    bit sample_taken = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int err_count = 0;
    int cycles = 0;

    function automatic longint mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Population variance below floor squared, in exact wide arithmetic.
    function automatic bit lane_stuck(longint s, longint q, logic [REG_W-1:0] floor_v);
        logic [127:0] lhs;
        logic [127:0] s2;
        logic [127:0] f2;
        lhs = q;
        lhs = lhs * WIN;
        s2  = mag64(s);
        s2  = s2 * s2;
        f2  = floor_v;
        f2  = f2 * f2 * (WIN * WIN);
        return lhs < (s2 + f2);
    endfunction

    task automatic push_lane(input int ln, input longint x);
        longint old;
        old = lane_hist[ln][lane_pos[ln]];
        lane_sum[ln] += x - old;
        lane_sq[ln]  += x * x - old * old;
        lane_hist[ln][lane_pos[ln]] = x;
        if (lane_pos[ln] == WIN - 1) begin
            lane_pos[ln]  = 0;
            lane_full[ln] = 1'b1;
        end else begin
            lane_pos[ln]++;
        end
    endtask

    task automatic update_health(input logic [IN_TDATA_W-1:0] word);
        longint  m;
        longint  o;
        longint  sel;
        bit      m_stuck;
        bit      o_stuck;
        bit      gap_bad;
        t_health r;
        m = longint'(signed'(word[RATE_W-1:0]));
        o = longint'(signed'(word[2*RATE_W-1:RATE_W]));
        push_lane(LANE_MEMS, m);
        if (cfg_optical_en)
            push_lane(LANE_OPT, o);

        r.mems_mean    = lane_full[LANE_MEMS] ? RATE_W'(lane_sum[LANE_MEMS] / WIN) : '0;
        r.optical_mean = lane_full[LANE_OPT] ? RATE_W'(lane_sum[LANE_OPT] / WIN) : '0;

        m_stuck = lane_stuck(lane_sum[LANE_MEMS], lane_sq[LANE_MEMS], cfg_mems_floor);
        o_stuck = lane_stuck(lane_sum[LANE_OPT], lane_sq[LANE_OPT], cfg_opt_floor);
        gap_bad = mag64(lane_sum[LANE_MEMS] - lane_sum[LANE_OPT]) > WIN * longint'(cfg_gap_limit);

        if (!lane_full[LANE_MEMS] || (cfg_optical_en && !lane_full[LANE_OPT])) begin
            r.status_code = gwhm_pkg::STATUS_UNAVAILABLE;
        end else if (!cfg_optical_en) begin
            r.status_code = m_stuck ? gwhm_pkg::STATUS_BAD : gwhm_pkg::STATUS_GOOD;
        end else if (mag64(lane_sum[LANE_MEMS]) > WIN * longint'(cfg_sat_guard)) begin
            r.status_code = gwhm_pkg::STATUS_GOOD;
        end else begin
            r.status_code = (gap_bad || m_stuck || o_stuck) ? gwhm_pkg::STATUS_BAD
                                                            : gwhm_pkg::STATUS_GOOD;
        end

        if (cfg_optical_en && lane_full[LANE_OPT])
            sel = lane_sum[LANE_OPT];
        else if (lane_full[LANE_MEMS])
            sel = lane_sum[LANE_MEMS];
        else
            sel = 0;
        r.not_rotating = mag64(sel) < WIN * longint'(cfg_rot_limit);
        health_reports.push_back(r);
    endtask

    // Sampling side: predict on every input transfer, check every output transfer.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[gyro_window_health_monitor] ERROR");
            $finish;
        end
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                update_health(s_axis_tdata);
                sample_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (health_reports.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result %h with nothing pending", m_axis_tdata);
                end else begin
                    t_health e;
                    e = health_reports.pop_front();
                    if (m_axis_tdata[1:0] !== e.status_code
                        || m_axis_tdata[31:2] !== e.mems_mean
                        || m_axis_tdata[61:32] !== e.optical_mean
                        || m_axis_tdata[62] !== e.not_rotating) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"mismatch: expected status %0d mems %0d optical %0d ",
                                      "still %0d, got status %0d mems %0d optical %0d still %0d"},
                                     e.status_code, $signed(e.mems_mean),
                                     $signed(e.optical_mean), e.not_rotating,
                                     m_axis_tdata[1:0], $signed(m_axis_tdata[31:2]),
                                     $signed(m_axis_tdata[61:32]), m_axis_tdata[62]);
                    end
                end
            end
        end
    end

    // Sample driver: holds tvalid until the transfer, idles in bursts between items.
    always @(negedge i_clk) begin
        if (i_rst_n && !(s_axis_tvalid && !sample_taken)) begin
            sample_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 6) - 1;
                s_axis_tvalid <= 1'b0;
            end else if (rate_samples.size() != 0) begin
                s_axis_tdata  <= rate_samples.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic longint clamp_rate(longint v);
        if (v > RATE_MAX)
            return RATE_MAX;
        if (v < RATE_MIN)
            return RATE_MIN;
        return v;
    endfunction

    function automatic longint rand_span(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    task automatic queue_pair(input longint m, input longint o);
        rate_samples.push_back({4'b0, RATE_W'(clamp_rate(o)), RATE_W'(clamp_rate(m))});
    endtask

    // A run of samples around a base rate with chosen noise, so the windows
    // settle into steady, noisy or diverging conditions.
    task automatic queue_segment(output int len);
        longint m_base;
        longint o_base;
        longint m_amp;
        longint o_amp;
        longint amps [7];
        int     k;
        amps = '{0, 1 << 8, 1 << 12, 1 << 16, 1 << 20, 1 << 24, RATE_MAX};
        len = $urandom_range(6, 30);
        if ($urandom_range(0, 7) == 0) begin
            for (k = 0; k < len; k++)
                queue_pair(rand_span(RATE_MAX), rand_span(RATE_MAX));
        end else begin
            case ($urandom_range(0, 3))
                0: m_base = rand_span(1 << 16);
                1: m_base = rand_span(1 << 22);
                2: m_base = rand_span(1 << 26);
                default: m_base = rand_span(RATE_MAX);
            endcase
            case ($urandom_range(0, 4))
                0: o_base = m_base;
                1: o_base = m_base + rand_span(1 << 14);
                2: o_base = m_base + rand_span(1 << 18);
                3: o_base = m_base + rand_span(1 << 21);
                default: o_base = m_base + rand_span(1 << 24);
            endcase
            m_amp = amps[$urandom_range(0, 5)];
            o_amp = amps[$urandom_range(0, 5)];
            for (k = 0; k < len; k++)
                queue_pair(m_base + rand_span(m_amp), o_base + rand_span(o_amp));
        end
    endtask

    task automatic queue_random(input int count);
        int done;
        int len;
        done = 0;
        while (done < count) begin
            queue_segment(len);
            done += len;
        end
    endtask

    // Wait until every queued sample has been sent and every result checked.
    // The check runs at the rising edge, after the driver's updates have settled.
    task automatic drain();
        while (rate_samples.size() != 0 || s_axis_tvalid || health_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            gwhm_pkg::CFG_OPTICAL_ENABLED:     cfg_optical_en = val[0];
            gwhm_pkg::CFG_DISCREPANCY_LIMIT:   cfg_gap_limit  = val;
            gwhm_pkg::CFG_MEMS_STUCK_FLOOR:    cfg_mems_floor = val;
            gwhm_pkg::CFG_OPTICAL_STUCK_FLOOR: cfg_opt_floor  = val;
            gwhm_pkg::CFG_SATURATION_GUARD:    cfg_sat_guard  = val;
            gwhm_pkg::CFG_ROTATION_LIMIT:      cfg_rot_limit  = val;
            default: ;
        endcase
    endtask

    // Ends a batch of writes and lets them take effect before samples resume.
    task automatic cfg_close();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        repeat (4) @(negedge i_clk);
    endtask

    // The enable bit goes out with random upper bits, which the block must drop.
    task automatic apply_settings(input bit en, input logic [REG_W-1:0] gap,
                                  input logic [REG_W-1:0] m_floor,
                                  input logic [REG_W-1:0] o_floor,
                                  input logic [REG_W-1:0] guard,
                                  input logic [REG_W-1:0] rot);
        cfg_write(gwhm_pkg::CFG_OPTICAL_ENABLED, {(REG_W-1)'($urandom), en});
        cfg_write(gwhm_pkg::CFG_DISCREPANCY_LIMIT, gap);
        cfg_write(gwhm_pkg::CFG_MEMS_STUCK_FLOOR, m_floor);
        cfg_write(gwhm_pkg::CFG_OPTICAL_STUCK_FLOOR, o_floor);
        cfg_write(gwhm_pkg::CFG_SATURATION_GUARD, guard);
        cfg_write(gwhm_pkg::CFG_ROTATION_LIMIT, rot);
        cfg_write(CFG_SPARE_LO, REG_W'($urandom));
        cfg_write(CFG_SPARE_HI, REG_W'($urandom));
        cfg_close();
    endtask

    // Settings as they come out of reset.
    task automatic apply_defaults(input bit en);
        apply_settings(en, gwhm_pkg::RST_DISCREPANCY_LIMIT, gwhm_pkg::RST_MEMS_STUCK_FLOOR,
                       gwhm_pkg::RST_OPTICAL_STUCK_FLOOR, gwhm_pkg::RST_SATURATION_GUARD,
                       gwhm_pkg::RST_ROTATION_LIMIT);
    endtask

    function automatic logic [REG_W-1:0] pick_reg(int unsigned typical);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return REG_W'($urandom_range(0, typical));
        endcase
    endfunction

    initial begin
        int k;
        int ph;
        for (k = 0; k < 2; k++) begin
            lane_sum[k]  = 0;
            lane_sq[k]   = 0;
            lane_pos[k]  = 0;
            lane_full[k] = 1'b0;
            for (int j = 0; j < WIN; j++)
                lane_hist[k][j] = 0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: a constant fill is unavailable until the window is full,
        // then stuck; then full-scale extremes and a saturated MEMS run.
        for (k = 0; k < WIN; k++)
            queue_pair(1 << 20, 1 << 20);
        queue_pair(RATE_MAX, RATE_MIN);
        queue_pair(RATE_MIN, RATE_MAX);
        queue_pair(0, 0);
        for (k = 0; k < 5; k++)
            queue_pair(RATE_MAX, 0);
        drain();

        // Optical channel off: its window must hold while samples keep coming.
        apply_defaults(1'b0);
        for (k = 0; k < 4; k++)
            queue_pair(rand_span(RATE_MAX), rand_span(RATE_MAX));
        drain();
        cfg_write(gwhm_pkg::CFG_OPTICAL_ENABLED, 31'd1);
        cfg_close();
        for (k = 0; k < 3; k++)
            queue_pair(rand_span(1 << 20), rand_span(1 << 20));
        drain();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apply_settings(1'b1, '0, '0, '0, '0, '0);
                1: apply_settings(1'b1, '1, '1, '1, '1, '1);
                2: apply_settings(1'b0, pick_reg(1 << 22), pick_reg(1 << 16),
                                  pick_reg(1 << 16), pick_reg(1 << 29), pick_reg(1 << 25));
                7: begin
                    apply_defaults(1'b1);
                    calm = 1'b1;
                end
                default: apply_settings($urandom_range(0, 3) != 0, pick_reg(1 << 22),
                                        pick_reg(1 << 16), pick_reg(1 << 16),
                                        pick_reg(1 << 29), pick_reg(1 << 25));
            endcase
            queue_random(PHASE_ITEMS);
            drain();
        end

        if (err_count == 0 && health_reports.size() == 0)
            $display("[gyro_window_health_monitor] OK");
        else
            $display("[gyro_window_health_monitor] ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/gwhm_pkg.sv
hw/rtl/gwhm_lane.sv
hw/rtl/gwhm_merge.sv
hw/rtl/gyro_window_health_monitor.sv
sim/testbench.sv
